### src/agr_pkg.sv
// Package for the linear gain ramp: constants, controller states, command and status types.
package agr_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int GAIN_FRAC_DEF     = 31;

  localparam int TARGET_BITS       = 17;
  localparam int TARGET_FRAC       = 16;
  localparam logic [TARGET_BITS-1:0] UNITY_TARGET = 17'h10000;

  localparam int RAMP_BITS         = 21;
  localparam logic [RAMP_BITS-1:0] RAMP_RESET = 21'd480;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_STEP,
    S_WALK,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic div_step;
    logic step_set;
    logic walk;
    logic mul_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic cnt_last;
    logic out_free;
  } status_t;

endpackage

### src/audio_gain_linear_ramp.sv
// Top level of the linear gain ramp: controller plus datapath.
// Each input passes through the check, walk, multiply and output states; on a target change,
// the serial divider (one divider bit per cycle) and the step state run between check and walk.
// A new input is taken only once the last result has been loaded into the output register.
// Reset clears gain, step and last target to zero and ramp_samples to 480.
module audio_gain_linear_ramp #(
  parameter int SAMPLE_BITS = agr_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = agr_pkg::GAIN_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [agr_pkg::RAMP_BITS-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in,
  input  logic [agr_pkg::TARGET_BITS-1:0] target_gain,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   sample_out
);

  agr_pkg::cmd_t    cmd;
  agr_pkg::status_t status;

  assign cfg_ready = 1'b1;

  agr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  agr_datapath #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .sample_in   (sample_in),
    .target_gain (target_gain),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out)
  );

endmodule

### src/agr_ctrl.sv
// Controller state machine sequencing check, divide, step, walk, multiply and output.
module agr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  agr_pkg::status_t status,
  output agr_pkg::cmd_t    cmd
);

  agr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= agr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      agr_pkg::S_IDLE: begin
        if (in_valid) state_next = agr_pkg::S_CHECK;
      end
      agr_pkg::S_CHECK: begin
        state_next = status.changed ? agr_pkg::S_DIV : agr_pkg::S_WALK;
      end
      agr_pkg::S_DIV: begin
        if (status.cnt_last) state_next = agr_pkg::S_STEP;
      end
      agr_pkg::S_STEP: begin
        state_next = agr_pkg::S_WALK;
      end
      agr_pkg::S_WALK: begin
        state_next = agr_pkg::S_MUL;
      end
      agr_pkg::S_MUL: begin
        if (status.cnt_last) state_next = agr_pkg::S_DONE;
      end
      agr_pkg::S_DONE: begin
        if (status.out_free) state_next = agr_pkg::S_IDLE;
      end
      default: begin
        state_next = agr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = (state != agr_pkg::S_IDLE);
    cmd.load     = (state == agr_pkg::S_IDLE) && in_valid;
    cmd.check    = (state == agr_pkg::S_CHECK);
    cmd.div_step = (state == agr_pkg::S_DIV);
    cmd.step_set = (state == agr_pkg::S_STEP);
    cmd.walk     = (state == agr_pkg::S_WALK);
    cmd.mul_step = (state == agr_pkg::S_MUL);
    cmd.out_load = (state == agr_pkg::S_DONE) && status.out_free;
  end

endmodule

### src/agr_datapath.sv
// Datapath: ramp register, gain state, serial divider, shift-add multiplier, output register.
module agr_datapath #(
  parameter int SAMPLE_BITS = agr_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = agr_pkg::GAIN_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [agr_pkg::RAMP_BITS-1:0]       cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  input  logic [agr_pkg::TARGET_BITS-1:0]     target_gain,
  input  agr_pkg::cmd_t                       cmd,
  output agr_pkg::status_t                    status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       sample_out
);

  localparam int GW   = GAIN_FRACTION_BITS + 1;
  localparam int RW   = agr_pkg::RAMP_BITS + 1;
  localparam int PW   = SAMPLE_BITS + GW;
  localparam int CMAX = (GW > SAMPLE_BITS) ? GW : SAMPLE_BITS;
  localparam int CW   = $clog2(CMAX + 1);
  localparam int TSH  = GAIN_FRACTION_BITS - agr_pkg::TARGET_FRAC;

  logic [agr_pkg::RAMP_BITS-1:0]   ramp_samples;
  logic [agr_pkg::TARGET_BITS-1:0] tq;
  logic [agr_pkg::TARGET_BITS-1:0] last_target;
  logic                            neg;
  logic [SAMPLE_BITS-1:0]          mag;
  logic [SAMPLE_BITS-1:0]          mag_sr;
  logic [GW-1:0]                   current_gain;
  logic [GW-1:0]                   gain_step;
  logic [GW-1:0]                   q_sr;
  logic [RW-1:0]                   rem;
  logic                            dist_nz;
  logic [CW-1:0]                   cnt;
  logic [PW-1:0]                   acc;
  logic [PW-1:0]                   mcand;

  logic [GW-1:0]                   tg_new;
  logic [GW-1:0]                   tg_last;
  logic [GW-1:0]                   gain_dist;
  logic [GW-1:0]                   gain_next;
  logic [agr_pkg::RAMP_BITS-1:0]   len;
  logic [RW-1:0]                   rem_sh;
  logic [SAMPLE_BITS-1:0]          q_out;

  assign tg_new    = GW'(tq) << TSH;
  assign tg_last   = GW'(last_target) << TSH;
  assign gain_dist = (tg_new > current_gain) ? (tg_new - current_gain) :
                                               (current_gain - tg_new);
  assign len       = (ramp_samples == '0) ? agr_pkg::RAMP_BITS'(1) : ramp_samples;
  assign rem_sh    = {rem[RW-2:0], q_sr[GW-1]};
  assign q_out     = acc[GAIN_FRACTION_BITS +: SAMPLE_BITS];

  always_comb begin
    gain_next = current_gain;
    if (current_gain < tg_last) begin
      gain_next = ((tg_last - current_gain) > gain_step) ? (current_gain + gain_step) : tg_last;
    end else if (current_gain > tg_last) begin
      gain_next = ((current_gain - tg_last) > gain_step) ? (current_gain - gain_step) : tg_last;
    end
  end

  assign status.changed  = (tq != last_target);
  assign status.cnt_last = (cnt == CW'(1));
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_samples <= agr_pkg::RAMP_RESET;
      last_target  <= '0;
      current_gain <= '0;
      gain_step    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) ramp_samples <= cfg_data;
      if (cmd.check && status.changed) last_target <= tq;
      if (cmd.step_set) begin
        gain_step <= (q_sr == '0 && dist_nz) ? GW'(1) : q_sr;
      end
      if (cmd.walk) current_gain <= gain_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= sample_in[SAMPLE_BITS-1];
      mag <= sample_in[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - sample_in) : sample_in;
      tq  <= (target_gain > agr_pkg::UNITY_TARGET) ? agr_pkg::UNITY_TARGET : target_gain;
    end
    if (cmd.check) begin
      q_sr    <= gain_dist;
      dist_nz <= (gain_dist != '0);
      rem     <= '0;
      cnt     <= CW'(GW);
    end
    if (cmd.div_step) begin
      if (rem_sh >= RW'(len)) begin
        rem  <= rem_sh - RW'(len);
        q_sr <= {q_sr[GW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        q_sr <= {q_sr[GW-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
    end
    if (cmd.walk) begin
      acc    <= PW'(1) << (GAIN_FRACTION_BITS - 1);
      mcand  <= PW'(gain_next);
      mag_sr <= mag;
      cnt    <= CW'(SAMPLE_BITS);
    end
    if (cmd.mul_step) begin
      if (mag_sr[0]) acc <= acc + mcand;
      mcand  <= mcand << 1;
      mag_sr <= mag_sr >> 1;
      cnt    <= cnt - CW'(1);
    end
    if (cmd.out_load) begin
      sample_out <= neg ? (SAMPLE_BITS'(0) - q_out) : q_out;
    end
  end

endmodule

### src/agr_checker.sv
// Port-level assertions for the linear gain ramp, bound to the top level.
module agr_checker #(
  parameter int SAMPLE_BITS = agr_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] sample_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while input still blocked");

endmodule

bind audio_gain_linear_ramp agr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_agr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out)
);
